// ===== src/aoc_pkg.sv =====
// Shared types and constants for the alpha-over compositing pipeline.
// Depends on nothing; every other file in src imports it.
package aoc_pkg;

  localparam logic [7:0] ChMax = 8'd255;
  localparam int unsigned ChanW = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ProdW = 16;
  localparam int unsigned DenW = 16;
  localparam int unsigned NumW = 24;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages = ChanW / StepsPerStage;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] a;
  } aoc_pix_t;

  // One color channel of the restoring divider: partial remainder and quotient.
  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [ChanW-1:0] quo;
  } aoc_lane_t;

  // Everything that travels through the divider stages with one pixel.
  typedef struct packed {
    logic                           bypass;
    logic [NumChan-1:0][ChanW-1:0]  down_c;
    logic [ChanW-1:0]               alpha;
    logic [NumW-1:0]                dsh;
    aoc_lane_t [NumChan-1:0]        lane;
  } aoc_div_t;

endpackage

// ===== src/aoc_prod.sv =====
// Front end of the compositor: products, denominator, numerators and alpha.
// Two register stages with per-stage valid/ready. Depends on aoc_pkg.
module aoc_prod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aoc_pkg::aoc_pix_t up_i,
  input  aoc_pkg::aoc_pix_t down_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aoc_pkg::aoc_div_t out_o
);
  import aoc_pkg::*;

  logic [NumChan-1:0][ChanW-1:0] up_c, down_c;
  logic [ChanW-1:0]              w_d, w_q;
  logic [NumChan-1:0][ProdW-1:0] pu_d, pu_q, pd_d, pd_q;
  logic [DenW-1:0]               den_d, den_q;
  logic                          byp_d, byp_q;
  logic [NumChan-1:0][ChanW-1:0] dc_q;
  logic [ChanW-1:0]              da_q;
  logic                          s1_valid_q, s2_ready;
  logic [DenW-1:0]               rnd, rnd_sum;
  aoc_div_t                      s2_d, s2_q;
  logic                          s2_valid_q;

  assign up_c   = {up_i.b, up_i.g, up_i.r};
  assign down_c = {down_i.b, down_i.g, down_i.r};

  // Stage 1: the 8x8 products and the denominator.
  always_comb begin
    w_d   = ChMax - up_i.a;
    byp_d = (up_i.a == '0);
    for (int i = 0; i < NumChan; i++) begin
      pu_d[i] = ProdW'(up_c[i]) * ProdW'(up_i.a);
      pd_d[i] = ProdW'(down_c[i]) * ProdW'(down_i.a);
    end
    den_d = (DenW'(up_i.a) << ChanW) - DenW'(up_i.a) + DenW'(down_i.a) * DenW'(w_d);
  end

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      w_q   <= w_d;
      pu_q  <= pu_d;
      pd_q  <= pd_d;
      den_q <= den_d;
      byp_q <= byp_d;
      dc_q  <= down_c;
      da_q  <= down_i.a;
    end
  end

  // Stage 2: numerators, rounded alpha, divisor aligned to the top quotient bit.
  always_comb begin
    // round(den/255) as floor((den+127)/255), via x/255 = (x+1 + ((x+1)>>8)) >> 8
    rnd     = den_q + DenW'(128);
    rnd_sum = rnd + (rnd >> ChanW);
    s2_d.bypass = byp_q;
    s2_d.down_c = dc_q;
    s2_d.alpha  = byp_q ? da_q : rnd_sum[DenW-1:ChanW];
    s2_d.dsh    = NumW'(den_q) << (ChanW - 1);
    for (int i = 0; i < NumChan; i++) begin
      s2_d.lane[i].rem = (NumW'(pu_q[i]) << ChanW) - NumW'(pu_q[i])
                       + NumW'(pd_q[i]) * NumW'(w_q);
      s2_d.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

endmodule

// ===== src/aoc_div_stage.sv =====
// One stage of the restoring divider: two quotient bits for all three channels.
// Depends on aoc_pkg.
module aoc_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aoc_pkg::aoc_div_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aoc_pkg::aoc_div_t out_o
);
  import aoc_pkg::*;

  aoc_div_t data_d, data_q;
  logic     valid_q;

  // Compare, subtract, shift the divisor down one place per step.
  always_comb begin
    data_d = in_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int i = 0; i < NumChan; i++) begin
        if (data_d.lane[i].rem >= data_d.dsh) begin
          data_d.lane[i].rem = data_d.lane[i].rem - data_d.dsh;
          data_d.lane[i].quo = {data_d.lane[i].quo[ChanW-2:0], 1'b1};
        end else begin
          data_d.lane[i].quo = {data_d.lane[i].quo[ChanW-2:0], 1'b0};
        end
      end
      data_d.dsh = data_d.dsh >> 1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ===== src/alpha_over_composite_pixel_top.sv =====
// Pipeline: 6 register stages (2 product, 4 divider of 2 quotient bits each); a result
// passes through all six before out_valid_o rises. Throughput: one pixel per cycle while
// the output is not stalled. Every stage has its own valid/ready, so a stalled output
// holds only the last stage and empty stages upstream keep filling.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers are not reset.
// Depends on aoc_pkg, aoc_prod and aoc_div_stage.
module alpha_over_composite_pixel_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] up_red_i,
  input  logic [7:0] up_green_i,
  input  logic [7:0] up_blue_i,
  input  logic [7:0] up_alpha_i,
  input  logic [7:0] down_red_i,
  input  logic [7:0] down_green_i,
  input  logic [7:0] down_blue_i,
  input  logic [7:0] down_alpha_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);
  import aoc_pkg::*;

  aoc_pix_t up_pix, down_pix;

  // Stage handshake chain: index 0 is the front end's output, index
  // DivStages the last divider stage.
  logic     [DivStages:0] st_valid;
  logic     [DivStages:0] st_ready;
  aoc_div_t [DivStages:0] st_data;

  assign up_pix   = '{r: up_red_i, g: up_green_i, b: up_blue_i, a: up_alpha_i};
  assign down_pix = '{r: down_red_i, g: down_green_i, b: down_blue_i, a: down_alpha_i};

  // Products, denominator, numerators and the rounded alpha.
  aoc_prod u_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .up_i        (up_pix),
    .down_i      (down_pix),
    .out_valid_o (st_valid[0]),
    .out_ready_i (st_ready[0]),
    .out_o       (st_data[0])
  );

  // Divider: quotient bits advance from the top, two per stage. The numerator
  // never exceeds 255 times the denominator, so eight bits hold the quotient
  // and the saturation clamp is implicit.
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    aoc_div_stage u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[k]),
      .in_ready_o  (st_ready[k]),
      .in_i        (st_data[k]),
      .out_valid_o (st_valid[k+1]),
      .out_ready_i (st_ready[k+1]),
      .out_o       (st_data[k+1])
    );
  end

  assign st_ready[DivStages] = out_ready_i;
  assign out_valid_o         = st_valid[DivStages];

  // Transparent upper pixel: pass the lower color through; the divider
  // result is meaningless then. Alpha was already selected up front.
  assign out_red_o   = st_data[DivStages].bypass ? st_data[DivStages].down_c[0]
                                                 : st_data[DivStages].lane[0].quo;
  assign out_green_o = st_data[DivStages].bypass ? st_data[DivStages].down_c[1]
                                                 : st_data[DivStages].lane[1].quo;
  assign out_blue_o  = st_data[DivStages].bypass ? st_data[DivStages].down_c[2]
                                                 : st_data[DivStages].lane[2].quo;
  assign out_alpha_o = st_data[DivStages].alpha;

endmodule
